// ===== design/tkcs_pkg.sv =====
// ----------------------------------------------------------------------------
// tkcs_pkg
// Shared types and constants of the top-k correlation selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tkcs_pkg;

  localparam int K_MAX_DEF      = 16;
  localparam int INDEX_BITS_DEF = 16;
  localparam int VAL_W          = 16;
  localparam int FIELD_IDX_W    = 16;
  localparam int KEEP_W         = 6;
  localparam int MAG_W          = 16;
  localparam int QUEUE_DEPTH    = 4;
  localparam int ADDR_W         = 4;
  localparam int DATA_W         = 32;

  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(16);

  typedef enum logic [1:0] {
    REG_KEEP_COUNT = 2'd0,
    REG_ALLOW_SELF = 2'd1,
    REG_MIN_MAG    = 2'd2
  } reg_idx_e;

  typedef enum logic {
    BACK_RUN,
    BACK_DRAIN
  } back_state_e;

  // Classified item as it travels from the front end to the back end.
  typedef struct packed {
    logic                          keep;
    logic                          neg;
    logic                          eor;
    logic signed [VAL_W-1:0]       value;
    logic        [FIELD_IDX_W-1:0] partner;
    logic        [FIELD_IDX_W-1:0] row;
  } queue_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } list_op_t;

endpackage

// ===== design/tkcs_front.sv =====
// ----------------------------------------------------------------------------
// tkcs_front
// Front end: masks indices and decides whether an accepted item is kept.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tkcs_front #(
  parameter int INDEX_BITS = tkcs_pkg::INDEX_BITS_DEF
) (
  input  logic                                    accept_i,
  input  logic        [tkcs_pkg::FIELD_IDX_W-1:0] row_id_i,
  input  logic        [tkcs_pkg::FIELD_IDX_W-1:0] partner_id_i,
  input  logic signed [tkcs_pkg::VAL_W-1:0]       corr_value_i,
  input  logic                                    row_ok_i,
  input  logic                                    partner_ok_i,
  input  logic                                    end_of_row_i,
  input  logic                                    allow_self_i,
  input  logic        [tkcs_pkg::MAG_W-1:0]       min_mag_i,
  output logic                                    push_o,
  output tkcs_pkg::queue_item_t                   item_o
);
  import tkcs_pkg::*;

  localparam int IDX_W = (INDEX_BITS < FIELD_IDX_W) ? INDEX_BITS : FIELD_IDX_W;
  localparam logic [FIELD_IDX_W-1:0] IDX_MASK =
    FIELD_IDX_W'((FIELD_IDX_W + 1)'(1) << IDX_W) - FIELD_IDX_W'(1);

  logic [FIELD_IDX_W-1:0] row_m;
  logic [FIELD_IDX_W-1:0] partner_m;
  logic [MAG_W:0]         mag;
  logic                   keep;

  assign row_m     = row_id_i & IDX_MASK;
  assign partner_m = partner_id_i & IDX_MASK;

  // The most negative code has a magnitude of one full unit, hence the extra bit.
  assign mag = corr_value_i[VAL_W-1] ? ((MAG_W + 1)'(0) - (MAG_W + 1)'(corr_value_i))
                                     : (MAG_W + 1)'(corr_value_i);

  assign keep = row_ok_i && partner_ok_i && (allow_self_i || (row_m != partner_m)) &&
                (mag >= {1'b0, min_mag_i}) && (corr_value_i != '0);

  // A dropped item still travels when it closes the row, so the drain runs.
  assign push_o = accept_i && (keep || end_of_row_i);

  always_comb begin
    item_o.keep    = keep;
    item_o.neg     = corr_value_i[VAL_W-1];
    item_o.eor     = end_of_row_i;
    item_o.value   = corr_value_i;
    item_o.partner = partner_m;
    item_o.row     = row_m;
  end

endmodule

// ===== design/tkcs_fifo.sv =====
// ----------------------------------------------------------------------------
// tkcs_fifo
// Short queue of classified items between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tkcs_fifo #(
  parameter int DEPTH = tkcs_pkg::QUEUE_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  tkcs_pkg::queue_item_t   item_i,
  input  logic                    pop_i,
  output tkcs_pkg::queue_item_t   head_o,
  output tkcs_pkg::queue_status_t status_o
);
  import tkcs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  queue_item_t      mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign status_o.full  = (count_q == CNT_W'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== design/tkcs_list.sv =====
// ----------------------------------------------------------------------------
// tkcs_list
// Sorted list of the strongest entries of one sign: a compare-and-shift
// insertion chain that also shifts out from the head during the drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tkcs_list #(
  parameter int   K_MAX = tkcs_pkg::K_MAX_DEF,
  parameter int   IDX_W = tkcs_pkg::INDEX_BITS_DEF,
  parameter logic NEG   = 1'b0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tkcs_pkg::list_op_t                op_i,
  input  logic [$clog2(K_MAX + 1)-1:0]      keep_i,
  input  logic signed [tkcs_pkg::VAL_W-1:0] value_i,
  input  logic [IDX_W-1:0]                  partner_i,
  output logic signed [tkcs_pkg::VAL_W-1:0] head_value_o,
  output logic [IDX_W-1:0]                  head_partner_o,
  output logic [$clog2(K_MAX + 1)-1:0]      fill_o
);
  import tkcs_pkg::*;

  localparam int FILL_W = $clog2(K_MAX + 1);
  localparam int IW     = (K_MAX > 1) ? $clog2(K_MAX) : 1;

  logic signed [VAL_W-1:0] vals_q     [K_MAX];
  logic        [IDX_W-1:0] parts_q    [K_MAX];
  logic signed [VAL_W-1:0] prev_val   [K_MAX];
  logic        [IDX_W-1:0] prev_part  [K_MAX];
  logic signed [VAL_W-1:0] next_val   [K_MAX];
  logic        [IDX_W-1:0] next_part  [K_MAX];
  logic [FILL_W-1:0]       fill_q, fill_d;
  logic [FILL_W-1:0]       n_eff;
  logic [IW-1:0]           weak_idx;
  logic [K_MAX-1:0]        beat;
  logic [K_MAX-1:0]        place;
  logic [K_MAX-1:0]        new_here;
  logic [K_MAX-1:0]        move_here;
  logic                    full;
  logic                    ins_en;

  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      beat[i] = NEG ? (value_i < vals_q[i]) : (value_i > vals_q[i]);
    end
  end

  // A full list only takes a value that beats its weakest entry, which drops out.
  assign full     = (fill_q >= keep_i);
  assign weak_idx = IW'(fill_q - FILL_W'(1));
  assign ins_en   = op_i.ins && (!full || beat[weak_idx]);
  assign n_eff    = full ? (fill_q - FILL_W'(1)) : fill_q;

  // The new value lands after every entry that is at least as strong.
  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      place[i] = ((FILL_W'(i) < n_eff) && beat[i]) || (FILL_W'(i) == n_eff);
    end
    new_here = place & ~(place << 1);
    for (int i = 0; i < K_MAX; i++) begin
      move_here[i] = ((place << 1) >> i) != '0 ? (place[i] || (FILL_W'(i) <= n_eff)) &&
                     (FILL_W'(i) <= n_eff) && ((place << 1) & (K_MAX'(1) << i)) != '0
                     : 1'b0;
    end
  end

  always_comb begin
    prev_val[0]  = value_i;
    prev_part[0] = partner_i;
    for (int i = 1; i < K_MAX; i++) begin
      prev_val[i]  = vals_q[i-1];
      prev_part[i] = parts_q[i-1];
    end
    for (int i = 0; i < K_MAX - 1; i++) begin
      next_val[i]  = vals_q[i+1];
      next_part[i] = parts_q[i+1];
    end
    next_val[K_MAX-1]  = vals_q[K_MAX-1];
    next_part[K_MAX-1] = parts_q[K_MAX-1];
  end

  always_comb begin
    fill_d = fill_q;
    if (ins_en) begin
      fill_d = n_eff + FILL_W'(1);
    end else if (op_i.shift && (fill_q != '0)) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < K_MAX; i++) begin
      if (ins_en) begin
        if (new_here[i]) begin
          vals_q[i]  <= value_i;
          parts_q[i] <= partner_i;
        end else if (move_here[i]) begin
          vals_q[i]  <= prev_val[i];
          parts_q[i] <= prev_part[i];
        end
      end else if (op_i.shift) begin
        vals_q[i]  <= next_val[i];
        parts_q[i] <= next_part[i];
      end
    end
  end

  assign head_value_o   = vals_q[0];
  assign head_partner_o = parts_q[0];
  assign fill_o         = fill_q;

endmodule

// ===== design/tkcs_back.sv =====
// ----------------------------------------------------------------------------
// tkcs_back
// Back end: inserts kept items into the two sorted lists and drains them
// at end of row, positives first, then negatives.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tkcs_back #(
  parameter int K_MAX = tkcs_pkg::K_MAX_DEF,
  parameter int IDX_W = tkcs_pkg::INDEX_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  tkcs_pkg::queue_item_t                   head_i,
  input  tkcs_pkg::queue_status_t                 status_i,
  output logic                                    pop_o,
  input  logic        [tkcs_pkg::KEEP_W-1:0]      keep_count_i,
  output logic                                    result_valid_o,
  output logic        [tkcs_pkg::FIELD_IDX_W-1:0] out_row_o,
  output logic        [tkcs_pkg::FIELD_IDX_W-1:0] out_partner_o,
  output logic signed [tkcs_pkg::VAL_W-1:0]       out_value_o,
  output logic                                    sign_kind_o,
  output logic                                    last_of_row_o
);
  import tkcs_pkg::*;

  localparam int FILL_W = $clog2(K_MAX + 1);

  back_state_e             state_q, state_d;
  logic [IDX_W-1:0]        row_q, row_d;
  list_op_t                pos_op, neg_op;
  logic [FILL_W-1:0]       keep_eff;
  logic [FILL_W-1:0]       pos_fill, neg_fill;
  logic signed [VAL_W-1:0] pos_val, neg_val;
  logic [IDX_W-1:0]        pos_part, neg_part;
  logic                    emit;
  logic                    emit_neg;
  logic                    emit_last;
  logic                    res_valid_q;
  logic [IDX_W-1:0]        res_row_q;
  logic [IDX_W-1:0]        res_part_q;
  logic signed [VAL_W-1:0] res_val_q;
  logic                    res_neg_q;
  logic                    res_last_q;

  always_comb begin
    if (keep_count_i == '0) begin
      keep_eff = FILL_W'(1);
    end else if (keep_count_i > KEEP_W'(K_MAX)) begin
      keep_eff = FILL_W'(K_MAX);
    end else begin
      keep_eff = FILL_W'(keep_count_i);
    end
  end

  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    pop_o     = 1'b0;
    pos_op    = '0;
    neg_op    = '0;
    emit      = 1'b0;
    emit_neg  = 1'b0;
    emit_last = 1'b0;
    case (state_q)
      BACK_RUN: begin
        if (!status_i.empty) begin
          pop_o      = 1'b1;
          pos_op.ins = head_i.keep && !head_i.neg;
          neg_op.ins = head_i.keep && head_i.neg;
          if (head_i.eor) begin
            row_d   = head_i.row[IDX_W-1:0];
            state_d = BACK_DRAIN;
          end
        end
      end
      BACK_DRAIN: begin
        if (pos_fill != '0) begin
          emit         = 1'b1;
          pos_op.shift = 1'b1;
          emit_last    = (pos_fill == FILL_W'(1)) && (neg_fill == '0);
        end else if (neg_fill != '0) begin
          emit         = 1'b1;
          emit_neg     = 1'b1;
          neg_op.shift = 1'b1;
          emit_last    = (neg_fill == FILL_W'(1));
        end
        if (emit_last || ((pos_fill == '0) && (neg_fill == '0))) begin
          state_d = BACK_RUN;
        end
      end
      default: begin
        state_d = BACK_RUN;
      end
    endcase
  end

  tkcs_list #(
    .K_MAX (K_MAX),
    .IDX_W (IDX_W),
    .NEG   (1'b0)
  ) u_pos_list (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (pos_op),
    .keep_i         (keep_eff),
    .value_i        (head_i.value),
    .partner_i      (head_i.partner[IDX_W-1:0]),
    .head_value_o   (pos_val),
    .head_partner_o (pos_part),
    .fill_o         (pos_fill)
  );

  tkcs_list #(
    .K_MAX (K_MAX),
    .IDX_W (IDX_W),
    .NEG   (1'b1)
  ) u_neg_list (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (neg_op),
    .keep_i         (keep_eff),
    .value_i        (head_i.value),
    .partner_i      (head_i.partner[IDX_W-1:0]),
    .head_value_o   (neg_val),
    .head_partner_o (neg_part),
    .fill_o         (neg_fill)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BACK_RUN;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    if (emit) begin
      res_row_q  <= row_q;
      res_part_q <= emit_neg ? neg_part : pos_part;
      res_val_q  <= emit_neg ? neg_val : pos_val;
      res_neg_q  <= emit_neg;
      res_last_q <= emit_last;
    end
  end

  assign result_valid_o = res_valid_q;
  assign out_row_o      = FIELD_IDX_W'(res_row_q);
  assign out_partner_o  = FIELD_IDX_W'(res_part_q);
  assign out_value_o    = res_val_q;
  assign sign_kind_o    = res_neg_q;
  assign last_of_row_o  = res_last_q;

endmodule

// ===== design/top_k_correlation_selector_unit.sv =====
// ----------------------------------------------------------------------------
// top_k_correlation_selector_unit
// Streaming top-k selection of positive and negative correlation partners.
// ----------------------------------------------------------------------------
//   Channel   Handshake                         Payload
//   input     start, busy (taken: start & !busy) row_id_i .. end_of_row_i
//   result    result_valid_o                     out_row_o .. last_of_row_o
//   config    APB psel/penable/pwrite, pready=1  paddr, pwdata, prdata
//
// One item is taken per cycle while the four-entry queue has room; the back
// end inserts one item per cycle through the compare-and-shift chain outside
// the drain. At end of row it drains the kept pairs; with both lists empty
// it returns to run without a result. The queue fills meanwhile. Each result
// is registered and appears in the cycle after the drain step that selects
// it; the receiver cannot stall. Reset clears the fill counts and the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module top_k_correlation_selector_unit #(
  parameter int K_MAX      = tkcs_pkg::K_MAX_DEF,
  parameter int INDEX_BITS = tkcs_pkg::INDEX_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start,
  output logic                                    busy,
  input  logic        [tkcs_pkg::FIELD_IDX_W-1:0] row_id_i,
  input  logic        [tkcs_pkg::FIELD_IDX_W-1:0] partner_id_i,
  input  logic signed [tkcs_pkg::VAL_W-1:0]       corr_value_i,
  input  logic                                    row_ok_i,
  input  logic                                    partner_ok_i,
  input  logic                                    end_of_row_i,
  output logic                                    result_valid_o,
  output logic        [tkcs_pkg::FIELD_IDX_W-1:0] out_row_o,
  output logic        [tkcs_pkg::FIELD_IDX_W-1:0] out_partner_o,
  output logic signed [tkcs_pkg::VAL_W-1:0]       out_value_o,
  output logic                                    sign_kind_o,
  output logic                                    last_of_row_o,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic        [tkcs_pkg::ADDR_W-1:0]      paddr,
  input  logic        [tkcs_pkg::DATA_W-1:0]      pwdata,
  output logic        [tkcs_pkg::DATA_W-1:0]      prdata,
  output logic                                    pready
);
  import tkcs_pkg::*;

  localparam int IDX_W = (INDEX_BITS < FIELD_IDX_W) ? INDEX_BITS : FIELD_IDX_W;

  logic [KEEP_W-1:0] keep_count_q;
  logic              allow_self_q;
  logic [MAG_W-1:0]  min_mag_q;
  reg_idx_e          reg_idx;
  logic              cfg_write;
  logic              accept;
  logic              push;
  logic              pop;
  queue_item_t       push_item;
  queue_item_t       head_item;
  queue_status_t     q_status;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_e'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_count_q <= KEEP_RESET;
      allow_self_q <= 1'b0;
      min_mag_q    <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_KEEP_COUNT: keep_count_q <= pwdata[KEEP_W-1:0];
        REG_ALLOW_SELF: allow_self_q <= pwdata[0];
        REG_MIN_MAG:    min_mag_q    <= pwdata[MAG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KEEP_COUNT: prdata = DATA_W'(keep_count_q);
      REG_ALLOW_SELF: prdata = DATA_W'(allow_self_q);
      REG_MIN_MAG:    prdata = DATA_W'(min_mag_q);
      default:        prdata = '0;
    endcase
  end

  assign busy   = q_status.full;
  assign accept = start && !busy;

  tkcs_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .accept_i     (accept),
    .row_id_i     (row_id_i),
    .partner_id_i (partner_id_i),
    .corr_value_i (corr_value_i),
    .row_ok_i     (row_ok_i),
    .partner_ok_i (partner_ok_i),
    .end_of_row_i (end_of_row_i),
    .allow_self_i (allow_self_q),
    .min_mag_i    (min_mag_q),
    .push_o       (push),
    .item_o       (push_item)
  );

  tkcs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .head_o   (head_item),
    .status_o (q_status)
  );

  tkcs_back #(
    .K_MAX (K_MAX),
    .IDX_W (IDX_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head_item),
    .status_i       (q_status),
    .pop_o          (pop),
    .keep_count_i   (keep_count_q),
    .result_valid_o (result_valid_o),
    .out_row_o      (out_row_o),
    .out_partner_o  (out_partner_o),
    .out_value_o    (out_value_o),
    .sign_kind_o    (sign_kind_o),
    .last_of_row_o  (last_of_row_o)
  );

endmodule

// ===== design/tkcs_checker.sv =====
// ----------------------------------------------------------------------------
// tkcs_checker
// Port-level checks on the result stream of the top-k selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tkcs_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    result_valid_o,
  input logic        [tkcs_pkg::FIELD_IDX_W-1:0] out_row_o,
  input logic signed [tkcs_pkg::VAL_W-1:0]       out_value_o,
  input logic                                    sign_kind_o,
  input logic                                    last_of_row_o
);

  // A row drains without gaps until its final transaction.
  a_drain_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_of_row_o |=> result_valid_o)
    else $error("result drain paused before the last transaction of the row");

  a_row_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_of_row_o |=> $stable(out_row_o))
    else $error("row index changed within one drain");

  // Negatives follow positives, never the other way round within a row.
  a_sign_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_of_row_o && sign_kind_o |=> sign_kind_o)
    else $error("positive result after a negative one in the same row");

  a_pos_descending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_of_row_o && !sign_kind_o |=>
    sign_kind_o || (out_value_o <= $past(out_value_o)))
    else $error("positive results not in descending order");

  a_neg_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_of_row_o && sign_kind_o |=>
    (out_value_o >= $past(out_value_o)))
    else $error("negative results not in ascending order");

endmodule

bind top_k_correlation_selector_unit tkcs_checker u_tkcs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .result_valid_o (result_valid_o),
  .out_row_o      (out_row_o),
  .out_value_o    (out_value_o),
  .sign_kind_o    (sign_kind_o),
  .last_of_row_o  (last_of_row_o)
);
